FILE: rtl/irc_tok_pkg.sv
// ============================================================================
// irc_tok_pkg - shared types and codes of the IRC line tokenizer
// Result kinds, split modes, line-end bytes and the result beat struct.
// ============================================================================
package irc_tok_pkg;

  // Default sizing
  localparam int LINE_BYTES_DEF = 1024;
  localparam int MAX_PARAMS_DEF = 15;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int INDEX_W = 4;
  localparam int POS_W   = 10;
  localparam int LIMIT_W = 4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LINE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OUTSIDE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DROP    = 3'd4;

  // Split modes
  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_SPLIT  = 2'd1;
  localparam logic [1:0] MODE_COLON  = 2'd2;
  localparam logic [1:0] MODE_BEYOND = 2'd3;

  // Special bytes
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'd58;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd15;

  // One classified result beat
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] param_index;
    logic [POS_W-1:0]   line_pos;
    logic [INDEX_W-1:0] param_total;
  } result_t;

endpackage

FILE: rtl/irc_line_tokenizer.sv
// ============================================================================
// irc_line_tokenizer - IRC line and parameter tokenizer, one byte per beat
// Splits a received byte stream into CR/LF-ended lines and space-separated
// parameters and emits one classified result beat per input byte.
// ============================================================================
// Usage:
//   rx channel  (rx_valid/rx_ready/rx_byte): one received byte per beat.
//   out channel (out_valid/out_ready + kind, data_byte, param_index,
//               line_pos, param_total): one result beat per input byte,
//               in input order.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes param_limit; always
//               ready. Write it only while no byte is in flight.
// Pipeline: two register stages, byte stage then result register.
// Throughput: one byte per cycle while out_ready stays high; the only loop is
//   the line state update in the classifier, registered on each advance.
// Reset: rst (synchronous, active high) empties both stages, clears the line
//   state and sets param_limit to 15.
// Stall: while out_ready is low the result register holds its beat; the byte
//   stage still takes one more byte, then rx_ready drops until the result
//   register drains.
// ============================================================================
module irc_line_tokenizer #(
  parameter int LINE_BYTES = irc_tok_pkg::LINE_BYTES_DEF,
  parameter int MAX_PARAMS = irc_tok_pkg::MAX_PARAMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // byte input
  input  logic                                rx_valid,
  output logic                                rx_ready,
  input  logic [irc_tok_pkg::BYTE_W-1:0]      rx_byte,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [irc_tok_pkg::LIMIT_W-1:0]     cfg_data,
  // result output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [irc_tok_pkg::KIND_W-1:0]      kind,
  output logic [irc_tok_pkg::BYTE_W-1:0]      data_byte,
  output logic [irc_tok_pkg::INDEX_W-1:0]     param_index,
  output logic [irc_tok_pkg::POS_W-1:0]       line_pos,
  output logic [irc_tok_pkg::INDEX_W-1:0]     param_total
);
  import irc_tok_pkg::*;

  // Configuration register
  logic [LIMIT_W-1:0] param_limit;

  // Byte stage
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;

  // Result register
  result_t out_reg;
  result_t result;

  logic out_free;   // result register can take a beat this cycle
  logic advance;    // staged byte moves into the result register

  assign out_free  = !out_valid || out_ready;
  assign advance   = stage_valid && out_free;
  assign rx_ready  = !stage_valid || out_free;
  assign cfg_ready = 1'b1;

  // Hold the limit; any write beat replaces it.
  always_ff @(posedge clk) begin
    if (rst) begin
      param_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      param_limit <= cfg_data;
    end
  end

  // Byte stage: load on an accepted rx beat, empty when the byte advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      stage_byte <= rx_byte;
    end
  end

  // Classify the staged byte and advance the line state.
  irc_tok_core #(
    .LINE_BYTES (LINE_BYTES),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .rx_byte     (stage_byte),
    .param_limit (param_limit),
    .result      (result)
  );

  // Result register: load on advance, drop valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign kind        = out_reg.kind;
  assign data_byte   = out_reg.data_byte;
  assign param_index = out_reg.param_index;
  assign line_pos    = out_reg.line_pos;
  assign param_total = out_reg.param_total;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced byte did not reach the result register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !out_free) |=> (stage_valid && $stable(stage_byte)))
    else $error("staged byte lost while the result register was full");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind <= KIND_DROP))
    else $error("result kind out of range");

  a_total_on_line: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_LINE)) |-> (param_total == '0))
    else $error("parameter total set on a beat that does not end a line");

endmodule

FILE: rtl/irc_tok_core.sv
// ============================================================================
// irc_tok_core - line state and byte classifier
// Holds the per-line split state, classifies the staged byte and advances
// the state when the byte moves into the result register.
// ============================================================================
module irc_tok_core #(
  parameter int LINE_BYTES = irc_tok_pkg::LINE_BYTES_DEF,
  parameter int MAX_PARAMS = irc_tok_pkg::MAX_PARAMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic [irc_tok_pkg::BYTE_W-1:0]      rx_byte,
  input  logic [irc_tok_pkg::LIMIT_W-1:0]     param_limit,
  output irc_tok_pkg::result_t                result
);
  import irc_tok_pkg::*;

  localparam int LW = $clog2(LINE_BYTES);
  localparam int PW = $clog2(MAX_PARAMS + 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(LINE_BYTES - 1);

  logic [LW-1:0] line_length, line_length_next;
  logic [PW-1:0] params_found, params_found_next;
  logic [1:0]    split_mode, split_mode_next;
  logic          segment_started, segment_started_next;
  logic          segment_colon, segment_colon_next;

  logic [PW-1:0] lim;
  logic [PW-1:0] found_inc;
  logic          is_eol;
  logic          is_space;

  always_comb begin
    lim       = (32'(param_limit) > MAX_PARAMS) ? PW'(MAX_PARAMS) : PW'(param_limit);
    found_inc = params_found + PW'(1);
    is_eol    = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    is_space  = (rx_byte == CHAR_SPACE);

    line_length_next     = line_length;
    params_found_next    = params_found;
    split_mode_next      = split_mode;
    segment_started_next = segment_started;
    segment_colon_next   = segment_colon;

    result.kind        = KIND_TEXT;
    result.data_byte   = rx_byte;
    result.param_index = '0;
    result.line_pos    = POS_W'(line_length);
    result.param_total = '0;

    if (is_eol) begin
      result.kind        = KIND_LINE;
      result.param_total = INDEX_W'((split_mode == MODE_SPLIT) ? found_inc : params_found);
      line_length_next     = '0;
      params_found_next    = '0;
      split_mode_next      = MODE_FIRST;
      segment_started_next = 1'b0;
      segment_colon_next   = 1'b0;
    end else if (line_length == LEN_FULL) begin
      result.kind = KIND_DROP;
    end else begin
      line_length_next = line_length + LW'(1);
      unique case (split_mode)
        MODE_FIRST: begin
          if (is_space) begin
            result.kind          = KIND_SEP;
            params_found_next    = PW'(1);
            split_mode_next      = MODE_SPLIT;
            segment_started_next = 1'b0;
            segment_colon_next   = 1'b0;
          end
        end
        MODE_SPLIT: begin
          if (is_space) begin
            result.param_index = INDEX_W'(params_found);
            params_found_next  = found_inc;
            if (segment_started && segment_colon) begin
              // colon parameter swallows the space and the rest of the line
              result.kind     = KIND_TEXT;
              split_mode_next = MODE_COLON;
            end else begin
              result.kind     = KIND_SEP;
              split_mode_next = (found_inc >= lim) ? MODE_BEYOND : MODE_SPLIT;
            end
            segment_started_next = 1'b0;
            segment_colon_next   = 1'b0;
          end else begin
            if (!segment_started) begin
              segment_started_next = 1'b1;
              segment_colon_next   = (rx_byte == CHAR_COLON);
            end
            result.param_index = INDEX_W'(params_found);
          end
        end
        MODE_COLON: begin
          result.param_index = INDEX_W'(params_found - PW'(1));
        end
        MODE_BEYOND: begin
          result.kind = KIND_OUTSIDE;
        end
        default: begin
          result.kind = KIND_OUTSIDE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      params_found    <= '0;
      split_mode      <= MODE_FIRST;
      segment_started <= 1'b0;
      segment_colon   <= 1'b0;
    end else if (advance) begin
      line_length     <= line_length_next;
      params_found    <= params_found_next;
      split_mode      <= split_mode_next;
      segment_started <= segment_started_next;
      segment_colon   <= segment_colon_next;
    end
  end

endmodule
